// ----- src/mrpn_pkg.sv -----
// Shared types and constants for the MIDI RPN/NRPN event translator.
// No dependencies; mrpn_out_if and the translator import this package.
`default_nettype none

package mrpn_pkg;

  // input event codes
  localparam logic [3:0] EV_CONTROLLER    = 4'd0;
  localparam logic [3:0] EV_NRPN          = 4'd1;
  localparam logic [3:0] EV_RPN           = 4'd2;
  localparam logic [3:0] EV_PROGRAM       = 4'd3;
  localparam logic [3:0] EV_NOTE_ON       = 4'd4;
  localparam logic [3:0] EV_NOTE_OFF      = 4'd5;
  localparam logic [3:0] EV_KEY_PRESSURE  = 4'd6;
  localparam logic [3:0] EV_CHAN_PRESSURE = 4'd7;
  localparam logic [3:0] EV_BEND          = 4'd8;

  // controller numbers that drive the parameter state
  localparam logic [13:0] CC_DATA_MSB = 14'd6;
  localparam logic [13:0] CC_DATA_LSB = 14'd38;
  localparam logic [13:0] CC_NRPN_LSB = 14'd98;
  localparam logic [13:0] CC_NRPN_MSB = 14'd99;
  localparam logic [13:0] CC_RPN_LSB  = 14'd100;
  localparam logic [13:0] CC_RPN_MSB  = 14'd101;

  localparam logic [13:0] IDX_NULL = 14'h3FFF;

  localparam logic signed [14:0] BEND_NEAR_MAX = 15'sd8191;
  localparam logic signed [14:0] BEND_MAX      = 15'sd8192;

  // 65536 = 127 * 516 + 4
  localparam int SEVEN_DIV    = 127;
  localparam int Q16_PER_STEP = 516;

  typedef enum logic [3:0] {
    K_OFF        = 4'd0,
    K_ON         = 4'd1,
    K_AFTERTOUCH = 4'd2,
    K_CONTROL    = 4'd3,
    K_PROGRAM    = 4'd4,
    K_PRESSURE   = 4'd5,
    K_BEND       = 4'd6,
    K_RPN        = 4'd7,
    K_NRPN       = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    SC_SEVEN   = 2'd0,
    SC_PROGRAM = 2'd1,
    SC_BEND    = 2'd2
  } scale_mode_t;

  typedef struct packed {
    logic        registered;
    logic [13:0] index;
    logic [13:0] data;
  } chan_state_t;

  // message before value scaling
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         channel;
    logic               has_number;
    logic [13:0]        number;
    scale_mode_t        mode;
    logic signed [14:0] sval;
  } msg_pre_t;

endpackage

`default_nettype wire

// ----- src/mrpn_in_if.sv -----
// Input channel: one decoded MIDI event per item.
// Depends on nothing but the handshake signals defined here.
`default_nettype none

interface mrpn_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         event_type;
  logic [7:0]         channel;
  logic [13:0]        param;
  logic signed [14:0] value;

  modport source (output valid, event_type, channel, param, value, input ready);
  modport sink   (input valid, event_type, channel, param, value, output ready);
endinterface

`default_nettype wire

// ----- src/mrpn_out_if.sv -----
// Output channel: one synth message per item.
// Depends on mrpn_pkg for the message kind type.
`default_nettype none

interface mrpn_out_if
  import mrpn_pkg::*;
;
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [7:0]         out_channel;
  logic               has_number;
  logic [13:0]        number;
  logic signed [24:0] scaled_value;

  modport source (output valid, kind, out_channel, has_number, number, scaled_value,
                  input ready);
  modport sink   (input valid, kind, out_channel, has_number, number, scaled_value,
                  output ready);
endinterface

`default_nettype wire

// ----- src/mrpn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mrpn_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/midi_rpn_event_translator.sv -----
// MIDI RPN/NRPN event translator: per-channel parameter state in a RAM,
// read-modify-write pipeline, Q.16 value scaling. Uses mrpn_pkg, mrpn_ram
// and the mrpn_in_if / mrpn_out_if channel interfaces.
//
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+-----------
//  evt     | in  | event_type, channel, param, value              | valid/ready
//  msg     | out | kind, out_channel, has_number, number,         | valid/ready
//          |     | scaled_value                                   |
//
// One item per cycle sustained while msg.ready holds; a result is offered after
// state read at accept, modify/write-back and scaling into the output reg.
// The per-channel RAM is read at accept and written when the item leaves stage 1;
// a write register forwards to the next item on the same channel.
// Reset clears per-channel valid flops; no clearing pass.
// Events without a message never wait on msg.ready; controller ones update state.
`default_nettype none

module midi_rpn_event_translator
  import mrpn_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input wire logic clk,
  input wire logic rst,
  mrpn_in_if.sink  evt,
  mrpn_out_if.source msg
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SW = $bits(chan_state_t);

  // ---------------- stage 1: state read / modify / write back
  logic               s1_valid;
  logic [3:0]         s1_type;
  logic [7:0]         s1_channel;
  logic [13:0]        s1_param;
  logic signed [14:0] s1_value;
  logic               s1_in_range;
  logic               s1_rvalid;

  logic [NUM_CHANNELS-1:0] valid_bits;

  logic              fwd_valid;
  logic [AW-1:0]     fwd_addr;
  chan_state_t       fwd_data;

  logic              accept;
  logic              in_range;
  logic [AW-1:0]     s1_addr;
  logic [SW-1:0]     ram_rdata;
  chan_state_t       st;
  chan_state_t       st_next;
  logic              s1_we;
  logic              s1_emit;
  logic              s1_adv;
  logic              ram_we;
  msg_pre_t          pre;
  logic [13:0]       coarse;
  logic [13:0]       fine;

  // ---------------- stage 2 and output register
  logic        s2_valid;
  msg_pre_t    s2;
  logic        s2_adv;
  logic        s2_ready;

  logic               out_valid;
  kind_t              out_kind;
  logic [7:0]         out_channel;
  logic               out_has_number;
  logic [13:0]        out_number;
  logic signed [24:0] out_value;
  logic signed [24:0] scaled;

  assign in_range = {1'b0, evt.channel} < 9'(NUM_CHANNELS);
  assign accept   = evt.valid && evt.ready;
  assign s1_addr  = s1_channel[AW-1:0];

  assign s2_adv   = s2_valid && (!out_valid || msg.ready);
  assign s2_ready = !s2_valid || s2_adv;
  assign s1_adv   = s1_valid && (!s1_emit || s2_ready);
  assign evt.ready = !s1_valid || s1_adv;
  assign ram_we   = s1_adv && s1_we;

  mrpn_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (st_next),
    .re    (accept),
    .raddr (evt.channel[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_type     <= evt.event_type;
      s1_channel  <= evt.channel;
      s1_param    <= evt.param;
      s1_value    <= evt.value;
      s1_in_range <= in_range;
      s1_rvalid   <= in_range && valid_bits[evt.channel[AW-1:0]];
    end
  end

  // entry valid flags and the write-forward register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      fwd_valid  <= 1'b0;
    end else if (ram_we) begin
      valid_bits[s1_addr] <= 1'b1;
      fwd_valid           <= 1'b1;
    end
    if (ram_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= st_next;
    end
  end

  always_comb begin
    coarse = {s1_value[6:0], 7'b0};
    fine   = s1_value[13:0];
    priority if (fwd_valid && fwd_addr == s1_addr) begin
      st = fwd_data;
    end else if (s1_rvalid) begin
      st = chan_state_t'(ram_rdata);
    end else begin
      st = '0;
    end
    st_next        = st;
    s1_we          = 1'b0;
    s1_emit        = 1'b1;
    pre.kind       = K_CONTROL;
    pre.channel    = s1_channel;
    pre.has_number = 1'b1;
    pre.number     = s1_param;
    pre.mode       = SC_SEVEN;
    pre.sval       = s1_value;
    unique case (s1_type)
      EV_CONTROLLER: begin
        if (s1_in_range) begin
          priority if (s1_param == CC_DATA_MSB) begin
            st_next.data = coarse;
            s1_we        = 1'b1;
            s1_emit      = 1'b0;
          end else if (s1_param == CC_DATA_LSB) begin
            st_next.data = st.data | fine;
            s1_we        = 1'b1;
            s1_emit      = (st.index != IDX_NULL);
            pre.kind     = st.registered ? K_RPN : K_NRPN;
            pre.number   = st.index;
            pre.sval     = $signed({1'b0, st_next.data});
          end else if (s1_param == CC_NRPN_LSB || s1_param == CC_RPN_LSB) begin
            st_next.registered = (s1_param == CC_RPN_LSB);
            st_next.index      = st.index | fine;
            s1_we              = 1'b1;
            s1_emit            = 1'b0;
          end else if (s1_param == CC_NRPN_MSB || s1_param == CC_RPN_MSB) begin
            st_next.registered = (s1_param == CC_RPN_MSB);
            st_next.index      = coarse;
            s1_we              = 1'b1;
            s1_emit            = 1'b0;
          end
        end
      end
      EV_NRPN:          pre.kind = K_NRPN;
      EV_RPN:           pre.kind = K_RPN;
      EV_PROGRAM: begin
        pre.kind       = K_PROGRAM;
        pre.has_number = 1'b0;
        pre.number     = '0;
        pre.mode       = SC_PROGRAM;
      end
      EV_NOTE_ON:       pre.kind = K_ON;
      EV_NOTE_OFF:      pre.kind = K_OFF;
      EV_KEY_PRESSURE:  pre.kind = K_AFTERTOUCH;
      EV_CHAN_PRESSURE: begin
        pre.kind       = K_PRESSURE;
        pre.has_number = 1'b0;
        pre.number     = '0;
      end
      EV_BEND: begin
        pre.kind       = K_BEND;
        pre.has_number = 1'b0;
        pre.number     = '0;
        pre.mode       = SC_BEND;
      end
      default: s1_emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
    if (s1_adv && s1_emit) begin
      s2 <= pre;
    end
  end

  // ---------------- stage 2: Q.16 scaling
  // round(|v| * 65536 / 127) = |v| * 516 + floor((4|v| + 63) / 127)
  logic               neg;
  logic [14:0]        mag_in;
  logic [16:0]        y;
  logic [25:0]        yprod;
  logic [9:0]         q0;
  logic [16:0]        rem;
  logic [9:0]         q;
  logic [23:0]        mag;
  logic signed [24:0] seven_q16;
  logic signed [24:0] prog_q16;
  logic signed [14:0] bend_v;

  always_comb begin
    neg    = s2.sval[14];
    mag_in = neg ? 15'(-s2.sval) : 15'(s2.sval);
    y      = {mag_in, 2'b00} + 17'd63;
    // reciprocal estimate, low by at most one
    yprod  = 26'(y) * 26'(Q16_PER_STEP);
    q0     = yprod[25:16];
    rem    = y - 17'(q0) * 17'(SEVEN_DIV);
    q      = q0 + 10'(rem >= 17'(SEVEN_DIV));
    mag    = 24'(mag_in) * 24'(Q16_PER_STEP) + 24'(q);
    seven_q16 = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    priority if (s2.sval > 15'sd255) begin
      prog_q16 = 25'sh0FFFFFF;
    end else if (s2.sval < -15'sd256) begin
      prog_q16 = $signed(25'h1000000);
    end else begin
      prog_q16 = $signed({s2.sval[8:0], 16'h0000});
    end

    bend_v = (s2.sval == BEND_NEAR_MAX) ? BEND_MAX : s2.sval;

    unique case (s2.mode)
      SC_SEVEN:   scaled = seven_q16;
      SC_PROGRAM: scaled = prog_q16;
      SC_BEND:    scaled = $signed({{7{bend_v[14]}}, bend_v, 3'b000});
      default:    scaled = seven_q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (msg.ready) begin
      out_valid <= 1'b0;
    end
    if (s2_adv) begin
      out_kind       <= s2.kind;
      out_channel    <= s2.channel;
      out_has_number <= s2.has_number;
      out_number     <= s2.number;
      out_value      <= scaled;
    end
  end

  assign msg.valid        = out_valid;
  assign msg.kind         = out_kind;
  assign msg.out_channel  = out_channel;
  assign msg.has_number   = out_has_number;
  assign msg.number       = out_number;
  assign msg.scaled_value = out_value;

  // ---------------- assertions
  a_we_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (s1_in_range && s1_type == EV_CONTROLLER))
    else $error("state write for a channel without state");

  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!msg.valid && !s2_valid))
    else $error("message pending right after reset");

  a_s2_kept: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && out_valid && !msg.ready) |=> s2_valid)
    else $error("stage 2 item dropped while output stalled");

  // widest magnitude comes from a value of -16384
  a_seven_range: assert property (@(posedge clk) disable iff (rst)
    (msg.valid && msg.kind != K_PROGRAM) |->
      (msg.scaled_value <= 25'sd8454660 && msg.scaled_value >= -25'sd8454660))
    else $error("scaled value out of range");

endmodule

`default_nettype wire
